/* hw/rtl/max_gap_after_insertion_top_assert.svh */
// Assertion macros for the max gap block.
`ifndef MAX_GAP_AFTER_INSERTION_TOP_ASSERT_SVH
`define MAX_GAP_AFTER_INSERTION_TOP_ASSERT_SVH

// Same-cycle implication under the block reset.
`define MGA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the block reset.
`define MGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mga_pkg.sv */
package mga_pkg;

	localparam int POS_BITS    = 16;
	localparam int MAX_POINTS  = 1024;
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);

	// 4:1 reduction tree, one register per level
	localparam int TREE_STAGES = ($clog2(MAX_POINTS) + 1) / 2;
	localparam int TREE_LEAVES = 1 << (2 * TREE_STAGES);
	localparam int TREE_NODES  = (TREE_LEAVES - 1) / 3;

	// wait from a stable cell state to a valid tree root: leaf register plus tree levels
	localparam int PASS_LAT    = TREE_STAGES + 1;
	localparam int WAIT_W      = $clog2(PASS_LAT + 1);

	localparam logic [POS_BITS-1:0] SEG_RESET = POS_BITS'(65535);

	typedef struct packed {
		logic                dup;
		logic [POS_BITS-1:0] gap;
	} node_t;

endpackage

/* hw/rtl/mga_if.sv */
interface mga_in_if;
	import mga_pkg::*;

	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] position;

	modport source (output valid, output position, input ready);
	modport sink   (input valid, input position, output ready);
endinterface

interface mga_out_if;
	import mga_pkg::*;

	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] max_gap;
	logic                rejected;

	modport source (output valid, output max_gap, output rejected, input ready);
	modport sink   (input valid, input max_gap, input rejected, output ready);
endinterface

/* hw/rtl/max_gap_after_insertion_top.sv */
// Flow: a position is taken only in idle and goes through a check pass of the registered
// 4:1 gap reduction tree over the cell row; a rejected one gives its result from there,
// an inserted one after a second pass over the new set. A new position is taken only
// once the last result is loaded, which waits while the output register is held.
// Reset: arst_n clears the point count and sets the segment length to 65535; the cell
// row itself is not cleared, since the fill count marks which cells hold points.
module max_gap_after_insertion_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mga_pkg::POS_BITS-1:0] cfg_wdata,
	mga_in_if.sink                       in_ch,
	mga_out_if.source                    out_ch
);
	import mga_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,   // waiting for a position
		ST_CHK,    // tree pass on the current set: duplicate check and gap
		ST_MAX     // tree pass on the set after insertion
	} state_t;

	state_t              state_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [CNT_W-1:0]    count_q;
	logic [POS_BITS-1:0] len_q;
	logic [POS_BITS-1:0] p_q;
	logic                ov_q;
	logic [POS_BITS-1:0] out_gap_q;
	logic                out_rej_q;

	logic [POS_BITS-1:0] pt   [MAX_POINTS];
	logic                gt   [MAX_POINTS];
	node_t               leaf [MAX_POINTS];
	node_t               root;

	logic                bad;
	logic                ins;
	logic                out_free;
	logic                out_load;
	logic [POS_BITS-1:0] cur_gap;

	// Cell row: each cell holds one sorted point and sees its left neighbor.
	// On insert every cell past the new point's place takes its left neighbor's value.
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		if (i == 0) begin : g_first
			mga_cell u_cell (
				.clk     (clk),
				.p       (p_q),
				.len     (len_q),
				.left_pt ('0),
				.left_gt (1'b0),
				.count   (count_q),
				.idx     (CNT_W'(i)),
				.ins     (ins),
				.pt      (pt[i]),
				.gt      (gt[i]),
				.leaf    (leaf[i])
			);
		end else begin : g_rest
			mga_cell u_cell (
				.clk     (clk),
				.p       (p_q),
				.len     (len_q),
				.left_pt (pt[i-1]),
				.left_gt (gt[i-1]),
				.count   (count_q),
				.idx     (CNT_W'(i)),
				.ins     (ins),
				.pt      (pt[i]),
				.gt      (gt[i]),
				.leaf    (leaf[i])
			);
		end
	end

	// Reduces the per-cell duplicate flags and gaps; root follows the cell state through
	// the leaf registers and one register per tree level.
	mga_tree u_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	// Rejection: at an end or beyond, already present, or table full.
	assign bad = (p_q == '0) || (p_q >= len_q) || root.dup ||
		(count_q == CNT_W'(MAX_POINTS));
	assign ins      = (state_q == ST_CHK) && (wait_q == '0) && !bad;
	assign out_free = !ov_q || out_ch.ready;
	// result register loads: refused at the check pass, or after the second pass
	assign out_load = out_free && (wait_q == '0) &&
		(((state_q == ST_CHK) && bad) || (state_q == ST_MAX));
	// empty set: one gap spanning the whole segment
	assign cur_gap  = (count_q == '0) ? len_q : root.gap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wait_q    <= '0;
			count_q   <= '0;
			len_q     <= SEG_RESET;
			p_q       <= '0;
			ov_q      <= 1'b0;
			out_gap_q <= '0;
			out_rej_q <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			// length write empties the set
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (cfg_we) begin
				count_q <= '0;
			end else if (ins) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						p_q     <= in_ch.position;
						wait_q  <= WAIT_W'(PASS_LAT);
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - 1'b1;
					end else if (!bad) begin
						wait_q  <= WAIT_W'(PASS_LAT);
						state_q <= ST_MAX;
					end else if (out_free) begin
						out_gap_q <= cur_gap;
						out_rej_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_MAX: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - 1'b1;
					end else if (out_free) begin
						out_gap_q <= cur_gap;
						out_rej_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready     = (state_q == ST_IDLE);
	assign out_ch.valid    = ov_q;
	assign out_ch.max_gap  = out_gap_q;
	assign out_ch.rejected = out_rej_q;

	`include "max_gap_after_insertion_top_assert.svh"

	// fill count never passes the table size
	`MGA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_POINTS),
		"point count overflow")

	// an insert grows the set by exactly one
	`MGA_ASSERT_NEXT(a_ins_count, clk, arst_n, ins && !cfg_we,
		count_q == CNT_W'($past(count_q) + 1'b1), "insert did not bump count")

	// a fresh accepted result always comes from a non-empty set
	`MGA_ASSERT_NOW(a_acc_nonempty, clk, arst_n,
		$rose(ov_q) && !out_rej_q && !$past(cfg_we), count_q != '0,
		"accepted result with empty set")

endmodule

/* hw/rtl/mga_cell.sv */
module mga_cell (
	input  logic                         clk,
	input  logic [mga_pkg::POS_BITS-1:0] p,
	input  logic [mga_pkg::POS_BITS-1:0] len,
	input  logic [mga_pkg::POS_BITS-1:0] left_pt,
	input  logic                         left_gt,
	input  logic [mga_pkg::CNT_W-1:0]    count,
	input  logic [mga_pkg::CNT_W-1:0]    idx,
	input  logic                         ins,
	output logic [mga_pkg::POS_BITS-1:0] pt,
	output logic                         gt,
	output mga_pkg::node_t               leaf
);
	import mga_pkg::*;

	logic                occ;
	logic                slot;
	logic                last;
	logic [POS_BITS-1:0] pt_q;
	logic [POS_BITS-1:0] step_gap;
	logic [POS_BITS-1:0] end_gap;
	node_t               leaf_q;

	assign occ      = idx < count;
	assign slot     = idx == count;
	assign last     = CNT_W'(idx + 1'b1) == count;
	assign gt       = occ && (pt_q > p);
	assign step_gap = pt_q - left_pt;
	assign end_gap  = last ? (len - pt_q) : '0;

	always_ff @(posedge clk) begin
		// shift right behind the new point, or take it at the first larger cell or the slot
		if (ins) begin
			if (left_gt) begin
				pt_q <= left_pt;
			end else if (gt || slot) begin
				pt_q <= p;
			end
		end
		leaf_q.dup <= occ && (pt_q == p);
		leaf_q.gap <= !occ ? '0 : ((end_gap > step_gap) ? end_gap : step_gap);
	end

	assign pt   = pt_q;
	assign leaf = leaf_q;

endmodule

/* hw/rtl/mga_tree.sv */
module mga_tree (
	input  logic           clk,
	input  mga_pkg::node_t leaf [mga_pkg::MAX_POINTS],
	output mga_pkg::node_t root
);
	import mga_pkg::*;

	node_t node_q [TREE_NODES];
	node_t all_n  [TREE_NODES + TREE_LEAVES];

	function automatic node_t merge2(node_t a, node_t b);
		node_t r;
		r.dup = a.dup | b.dup;
		r.gap = (a.gap > b.gap) ? a.gap : b.gap;
		return r;
	endfunction

	// heap order: children of node n sit at 4n+1 .. 4n+4, leaves last
	always_comb begin
		for (int n = 0; n < TREE_NODES; n++) begin
			all_n[n] = node_q[n];
		end
		for (int l = 0; l < TREE_LEAVES; l++) begin
			all_n[TREE_NODES + l] = (l < MAX_POINTS) ? leaf[l] : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < TREE_NODES; n++) begin
			node_q[n] <= merge2(merge2(all_n[4*n+1], all_n[4*n+2]),
				merge2(all_n[4*n+3], all_n[4*n+4]));
		end
	end

	assign root = node_q[0];

endmodule
